/* sv/dual_bar_graph_glyph_builder_unit_macros.svh */
// Assertion macros shared by the glyph builder RTL.
`ifndef DUAL_BAR_GRAPH_GLYPH_BUILDER_UNIT_MACROS_SVH
`define DUAL_BAR_GRAPH_GLYPH_BUILDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define DBG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define DBG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define DBG_ASSERT(lbl, prop, msg)
`define DBG_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* sv/dbg_pkg.sv */
package dbg_pkg;

  // Fixed field widths.
  localparam int SPAN_W = 8;
  localparam int IDX_W = 4;
  localparam int PAT_W = 8;

  // A clamped span covers at most 16 digits, so its digit number needs 5 bits.
  localparam int SPAN_DIG_W = 5;
  localparam int STEP_W = 3;
  localparam int STEPS_PER_DIGIT = 5;

  localparam int NUM_DIGITS_DEF = 12;

  // A level or tick position split into digit and step within the digit.
  typedef struct packed {
    logic                  en;
    logic [SPAN_DIG_W-1:0] dig;
    logic [STEP_W-1:0]     step;
  } span_split_t;

endpackage

/* sv/dbg_span_split.sv */
module dbg_span_split #(
  parameter int NUM_DIGITS = dbg_pkg::NUM_DIGITS_DEF
) (
  input  logic [dbg_pkg::SPAN_W-1:0] span_i,
  input  logic                       tick_i,
  output dbg_pkg::span_split_t       split_o
);
  import dbg_pkg::*;

  localparam logic [SPAN_W-1:0] Lim = SPAN_W'(STEPS_PER_DIGIT * NUM_DIGITS);

  logic [SPAN_W-1:0]     clamped;
  logic [SPAN_W-1:0]     pos;
  logic [2*SPAN_W-1:0]   prod;
  logic [SPAN_DIG_W-1:0] quo;
  logic [SPAN_W-1:0]     quo5;
  logic [SPAN_W-1:0]     rem;

  // Saturate to the display width; a tick position counts from one.
  assign clamped = (span_i > Lim) ? Lim : span_i;
  assign pos = clamped - SPAN_W'(tick_i);

  // Divide by five through the reciprocal 205/1024, exact for 8-bit values.
  assign prod = {{SPAN_W{1'b0}}, pos} * (2*SPAN_W)'(205);
  assign quo = prod[10 +: SPAN_DIG_W];
  assign quo5 = {1'b0, quo, 2'b00} + {3'b000, quo};
  assign rem = pos - quo5;

  // A tick at position zero means no tick at all.
  assign split_o.en = !tick_i || (clamped != '0);
  assign split_o.dig = quo;
  assign split_o.step = rem[STEP_W-1:0];

endmodule

/* sv/dual_bar_graph_glyph_builder_unit.sv */
// The first result of an item passes the hold register and then the result register before it is valid.
// Each item yields one result per digit, NUM_DIGITS in all, stepped by the digit counter while the output is free.
// The next item is taken in the cycle that the last digit of the current one is issued.
// Reset (rst_ni low, asynchronous) empties the hold and output registers and clears
// the digit counter; no result is pending after reset.
`include "dual_bar_graph_glyph_builder_unit_macros.svh"

module dual_bar_graph_glyph_builder_unit #(
  parameter int NUM_DIGITS = dbg_pkg::NUM_DIGITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dbg_pkg::SPAN_W-1:0] top_level_i,
  input  logic [dbg_pkg::SPAN_W-1:0] bottom_level_i,
  input  logic [dbg_pkg::SPAN_W-1:0] top_peak_i,
  input  logic [dbg_pkg::SPAN_W-1:0] bottom_peak_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dbg_pkg::IDX_W-1:0]  digit_index_o,
  output logic [dbg_pkg::PAT_W-1:0]  first_pattern_byte_o,
  output logic [dbg_pkg::PAT_W-1:0]  second_pattern_byte_o,
  output logic                       final_digit_o
);
  import dbg_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_DIGITS - 1);

  // Full-digit bar pattern for steps of zero, partial pattern otherwise.
  function automatic logic [2*PAT_W-1:0] bar_bytes(input logic row,
                                                  input logic [STEP_W-1:0] steps);
    logic [2*PAT_W-1:0] res;
    res = '0;
    if (!row) begin
      unique case (steps)
        3'd0:    res = {8'h84, 8'h83};
        3'd1:    res = {8'h80, 8'h00};
        3'd2:    res = {8'h80, 8'h80};
        3'd3:    res = {8'h80, 8'h81};
        3'd4:    res = {8'h80, 8'h83};
        default: res = '0;
      endcase
    end else begin
      unique case (steps)
        3'd0:    res = {8'h48, 8'h38};
        3'd1:    res = {8'h40, 8'h00};
        3'd2:    res = {8'h40, 8'h20};
        3'd3:    res = {8'h40, 8'h30};
        3'd4:    res = {8'h40, 8'h38};
        default: res = '0;
      endcase
    end
    return res;
  endfunction

  // Single tick pattern at one step within a digit.
  function automatic logic [2*PAT_W-1:0] tick_bytes(input logic row,
                                                   input logic [STEP_W-1:0] step);
    logic [2*PAT_W-1:0] res;
    res = '0;
    if (!row) begin
      unique case (step)
        3'd0:    res = {8'h80, 8'h00};
        3'd1:    res = {8'h00, 8'h80};
        3'd2:    res = {8'h00, 8'h01};
        3'd3:    res = {8'h00, 8'h02};
        3'd4:    res = {8'h04, 8'h00};
        default: res = '0;
      endcase
    end else begin
      unique case (step)
        3'd0:    res = {8'h40, 8'h00};
        3'd1:    res = {8'h00, 8'h20};
        3'd2:    res = {8'h00, 8'h10};
        3'd3:    res = {8'h00, 8'h08};
        3'd4:    res = {8'h08, 8'h00};
        default: res = '0;
      endcase
    end
    return res;
  endfunction

  // Bar contribution of one row for the given digit.
  function automatic logic [2*PAT_W-1:0] bar_for(input logic row,
                                                input span_split_t lvl,
                                                input logic [SPAN_DIG_W-1:0] dig);
    logic [2*PAT_W-1:0] res;
    res = '0;
    if (dig < lvl.dig) begin
      res = bar_bytes(row, '0);
    end else if ((dig == lvl.dig) && (lvl.step != '0)) begin
      res = bar_bytes(row, lvl.step);
    end
    return res;
  endfunction

  // Tick contribution of one row for the given digit.
  function automatic logic [2*PAT_W-1:0] tick_for(input logic row,
                                                 input span_split_t pk,
                                                 input logic [SPAN_DIG_W-1:0] dig);
    logic [2*PAT_W-1:0] res;
    res = '0;
    if (pk.en && (dig == pk.dig)) begin
      res = tick_bytes(row, pk.step);
    end
    return res;
  endfunction

  span_split_t top_lvl_s, bot_lvl_s, top_pk_s, bot_pk_s;
  span_split_t top_lvl_q, bot_lvl_q, top_pk_q, bot_pk_q;

  logic               hold_vld_q, hold_vld_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               out_vld_q, out_vld_d;
  logic [IDX_W-1:0]   idx_q;
  logic [2*PAT_W-1:0] pat_q, pat_d;
  logic               fin_q;

  logic               out_free;
  logic               adv;
  logic               last;
  logic               in_acc;
  logic [SPAN_DIG_W-1:0] cur_dig;

  // Clamp and split each field into digit and step as the item arrives.
  dbg_span_split #(.NUM_DIGITS(NUM_DIGITS)) u_top_lvl (
    .span_i(top_level_i), .tick_i(1'b0), .split_o(top_lvl_s)
  );
  dbg_span_split #(.NUM_DIGITS(NUM_DIGITS)) u_bot_lvl (
    .span_i(bottom_level_i), .tick_i(1'b0), .split_o(bot_lvl_s)
  );
  dbg_span_split #(.NUM_DIGITS(NUM_DIGITS)) u_top_pk (
    .span_i(top_peak_i), .tick_i(1'b1), .split_o(top_pk_s)
  );
  dbg_span_split #(.NUM_DIGITS(NUM_DIGITS)) u_bot_pk (
    .span_i(bottom_peak_i), .tick_i(1'b1), .split_o(bot_pk_s)
  );

  // Handshake: a held item issues one digit whenever the output register frees up.
  assign out_free = !out_vld_q || out_ready_i;
  assign adv = hold_vld_q && out_free;
  assign last = (cnt_q == LastIdx);
  assign in_ready_o = !hold_vld_q || (adv && last);
  assign in_acc = in_valid_i && in_ready_o;

  // Next control state.
  always_comb begin
    hold_vld_d = hold_vld_q;
    cnt_d = cnt_q;
    if (adv) begin
      cnt_d = last ? '0 : cnt_q + 1'b1;
      if (last) begin
        hold_vld_d = 1'b0;
      end
    end
    if (in_acc) begin
      hold_vld_d = 1'b1;
    end
    out_vld_d = adv ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  // Glyph bytes of the current digit: OR of both bars and both ticks.
  assign cur_dig = {1'b0, cnt_q};
  assign pat_d = bar_for(1'b0, top_lvl_q, cur_dig) | bar_for(1'b1, bot_lvl_q, cur_dig)
               | tick_for(1'b0, top_pk_q, cur_dig) | tick_for(1'b1, bot_pk_q, cur_dig);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      cnt_q <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Hold register for the split item.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      top_lvl_q <= top_lvl_s;
      bot_lvl_q <= bot_lvl_s;
      top_pk_q <= top_pk_s;
      bot_pk_q <= bot_pk_s;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx_q <= cnt_q;
      pat_q <= pat_d;
      fin_q <= last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign digit_index_o = idx_q;
  assign first_pattern_byte_o = pat_q[PAT_W +: PAT_W];
  assign second_pattern_byte_o = pat_q[0 +: PAT_W];
  assign final_digit_o = fin_q;

  // The final mark sits exactly on the last digit.
  `DBG_ASSERT(a_final_on_last, out_valid_o |-> (final_digit_o == (digit_index_o == LastIdx)), "final mark on wrong digit")
  // The digit counter moves only when a digit is issued.
  `DBG_ASSERT(a_cnt_moves_on_adv, !adv |=> $stable(cnt_q), "digit counter moved without issue")
  // With no item held the counter rests at digit zero.
  `DBG_ASSERT(a_cnt_idle_zero, !hold_vld_q |-> (cnt_q == '0), "digit counter not at zero while idle")
  // No result is presented while reset is applied.
  `DBG_ASSERT_ALWAYS(a_reset_no_out, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
